// ===== rtl/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types, widths and helpers for the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
package nps_pkg;

    // Process table depth and derived index widths
    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    // Field widths
    localparam int ARR_W  = 16;
    localparam int BUR_W  = 16;
    localparam int PRI_W  = 8;
    localparam int PIDX_W = 4;
    localparam int TIME_W = 21;
    localparam int SUM_W  = 26;

    // Command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input item
    typedef struct packed {
        logic [ARR_W-1:0] arrival_time;
        logic [BUR_W-1:0] burst_time;
        logic [PRI_W-1:0] priority_level;
        logic             last_process;
    } t_in;

    // Result item
    typedef struct packed {
        logic [PIDX_W-1:0] process_index;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] waiting_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [SUM_W-1:0]  total_waiting;
        logic [SUM_W-1:0]  total_turnaround;
        logic              end_of_schedule;
    } t_out;

    // One stored process record
    typedef struct packed {
        logic [ARR_W-1:0] arrival_time;
        logic [BUR_W-1:0] burst_time;
        logic [PRI_W-1:0] priority_level;
    } t_rec;

    // Classified command handed from front to back
    typedef struct packed {
        t_rec rec;
        logic store;   // record fits in the table
        logic last;    // batch ends, schedule follows
    } t_cmd;

    // Strict priority win under the configured polarity
    function automatic logic prio_wins(input logic [PRI_W-1:0] a,
                                       input logic [PRI_W-1:0] b,
                                       input logic             high_is_high);
        prio_wins = high_is_high ? (a > b) : (a < b);
    endfunction

endpackage

// ===== rtl/nps_front.sv =====
// ----------------------------------------------------------------------------
// nps_front
// Accepts process records and classifies them: stored or dropped, last or not.
// ----------------------------------------------------------------------------
module nps_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  nps_pkg::t_in  i_item,
    input  logic          i_full,
    output logic          o_busy,
    output logic          o_push,
    output nps_pkg::t_cmd o_cmd
);

    logic [nps_pkg::CNT_W-1:0] r_cnt;   // records stored in this batch
    logic                      accept;
    logic                      fits;

    assign o_busy = i_full || !i_rst_n;
    assign accept = i_start && !o_busy;
    assign fits   = r_cnt < nps_pkg::CNT_W'(nps_pkg::MAX_PROCS);

    // Classified command toward the queue
    always_comb begin
        o_cmd.rec.arrival_time   = i_item.arrival_time;
        o_cmd.rec.burst_time     = i_item.burst_time;
        o_cmd.rec.priority_level = i_item.priority_level;
        o_cmd.store              = fits;
        o_cmd.last               = i_item.last_process;
    end
    assign o_push = accept;

    // Batch fill count, restarts after the last record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            if (i_item.last_process) begin
                r_cnt <= '0;
            end else if (fits) begin
                r_cnt <= r_cnt + nps_pkg::CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/nps_queue.sv =====
// ----------------------------------------------------------------------------
// nps_queue
// Short command queue that decouples the front from the scheduling back end.
// ----------------------------------------------------------------------------
module nps_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nps_pkg::t_cmd i_data,
    input  logic          i_pop,
    output nps_pkg::t_cmd o_data,
    output logic          o_empty,
    output logic          o_full
);

    nps_pkg::t_cmd               r_mem [nps_pkg::Q_DEPTH];
    logic [nps_pkg::Q_PTR_W-1:0] r_wp;
    logic [nps_pkg::Q_PTR_W-1:0] r_rp;
    logic [nps_pkg::Q_CNT_W-1:0] r_cnt;
    logic                        do_push;
    logic                        do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == nps_pkg::Q_CNT_W'(nps_pkg::Q_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == nps_pkg::Q_PTR_W'(nps_pkg::Q_DEPTH - 1)) ?
                        '0 : r_wp + nps_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == nps_pkg::Q_PTR_W'(nps_pkg::Q_DEPTH - 1)) ?
                        '0 : r_rp + nps_pkg::Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + nps_pkg::Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - nps_pkg::Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/nps_back.sv =====
// ----------------------------------------------------------------------------
// nps_back
// Process table and dispatch sequencer: one table scan per dispatch.
// ----------------------------------------------------------------------------
module nps_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  nps_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    output logic          o_valid,
    output nps_pkg::t_out o_result
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_TAIL,
        S_PICK,
        S_EMIT
    } t_state;

    t_state r_state;

    // Table memory, one registered read port
    nps_pkg::t_rec r_mem [nps_pkg::MAX_PROCS];
    nps_pkg::t_rec r_rd_data;
    logic          mem_we;

    // Run state
    logic                        r_hih;
    logic [nps_pkg::MAX_PROCS-1:0] r_done;
    logic [nps_pkg::CNT_W-1:0]   r_loaded;
    logic [nps_pkg::CNT_W-1:0]   r_ndisp;
    logic [nps_pkg::TIME_W-1:0]  r_time;
    logic [nps_pkg::SUM_W-1:0]   r_sumw;
    logic [nps_pkg::SUM_W-1:0]   r_sumt;
    logic                        r_first;

    // Scan pipeline
    logic [nps_pkg::IDX_W-1:0]   r_addr;
    logic                        r_cmp_vld;
    logic [nps_pkg::IDX_W-1:0]   r_cmp_idx;

    // Candidates: earliest, earliest with best priority, best arrived
    logic                        r_e_vld, r_g_vld, r_b_vld;
    nps_pkg::t_rec               r_e, r_g, r_b;
    logic [nps_pkg::IDX_W-1:0]   r_e_idx, r_g_idx, r_b_idx;

    // Selected dispatch
    nps_pkg::t_rec               r_sel;
    logic [nps_pkg::IDX_W-1:0]   r_sel_idx;
    logic [nps_pkg::TIME_W-1:0]  r_start;
    logic [nps_pkg::TIME_W-1:0]  r_wait;

    nps_pkg::t_out               r_result;
    logic                        r_valid;

    // Combinational helpers
    logic                        pend;
    logic [nps_pkg::TIME_W-1:0]  d_arr;
    logic [nps_pkg::TIME_W-1:0]  e_arr, g_arr;
    logic                        upd_e, upd_g, upd_b;
    logic                        last_addr;
    nps_pkg::t_rec               sel;
    logic [nps_pkg::IDX_W-1:0]   sel_idx;
    logic [nps_pkg::TIME_W-1:0]  sel_start;
    logic [nps_pkg::TIME_W-1:0]  n_compl;
    logic [nps_pkg::TIME_W-1:0]  n_turn;
    logic [nps_pkg::SUM_W-1:0]   n_sumw;
    logic [nps_pkg::SUM_W-1:0]   n_sumt;
    logic                        n_last;

    assign o_pop  = (r_state == S_LOAD) && !i_empty;
    assign mem_we = o_pop && i_cmd.store;

    // Table write at fill position, read at scan address
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_loaded[nps_pkg::IDX_W-1:0]] <= i_cmd.rec;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // Candidate compare on the entry returned by the table
    always_comb begin
        pend  = !r_done[r_cmp_idx];
        d_arr = nps_pkg::TIME_W'(r_rd_data.arrival_time);
        e_arr = nps_pkg::TIME_W'(r_e.arrival_time);
        g_arr = nps_pkg::TIME_W'(r_g.arrival_time);
        upd_e = r_cmp_vld && pend && (!r_e_vld || (d_arr < e_arr));
        upd_g = r_cmp_vld && pend &&
                (!r_g_vld || (d_arr < g_arr) ||
                 ((d_arr == g_arr) &&
                  nps_pkg::prio_wins(r_rd_data.priority_level,
                                     r_g.priority_level, r_hih)));
        upd_b = r_cmp_vld && pend && (d_arr <= r_time) &&
                (!r_b_vld ||
                 nps_pkg::prio_wins(r_rd_data.priority_level,
                                    r_b.priority_level, r_hih));
    end

    assign last_addr = (nps_pkg::CNT_W'(r_addr) + nps_pkg::CNT_W'(1)) == r_loaded;

    // Selection: first dispatch takes the earliest; idle gap jumps the clock
    always_comb begin
        if (r_first) begin
            sel     = r_e;
            sel_idx = r_e_idx;
        end else if (r_b_vld) begin
            sel     = r_b;
            sel_idx = r_b_idx;
        end else begin
            sel     = r_g;
            sel_idx = r_g_idx;
        end
        sel_start = (r_first || !r_b_vld) ?
                    nps_pkg::TIME_W'(sel.arrival_time) : r_time;
    end

    // Dispatch arithmetic
    always_comb begin
        n_compl = r_start + nps_pkg::TIME_W'(r_sel.burst_time);
        n_turn  = r_wait + nps_pkg::TIME_W'(r_sel.burst_time);
        n_sumw  = r_sumw + nps_pkg::SUM_W'(r_wait);
        n_sumt  = r_sumt + nps_pkg::SUM_W'(n_turn);
        n_last  = (r_ndisp + nps_pkg::CNT_W'(1)) == r_loaded;
    end

    // Sequencer, run state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_hih     <= 1'b1;
            r_done    <= '0;
            r_loaded  <= '0;
            r_ndisp   <= '0;
            r_time    <= '0;
            r_sumw    <= '0;
            r_sumt    <= '0;
            r_first   <= 1'b1;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
            r_e_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            // strobe for exactly the cycle after the emit state
            r_valid <= (r_state == S_EMIT);
            if (i_cfg_we) begin
                r_hih <= i_cfg_data;
            end

            // Candidate tracking
            if (upd_e) begin
                r_e_vld <= 1'b1;
                r_e     <= r_rd_data;
                r_e_idx <= r_cmp_idx;
            end
            if (upd_g) begin
                r_g_vld <= 1'b1;
                r_g     <= r_rd_data;
                r_g_idx <= r_cmp_idx;
            end
            if (upd_b) begin
                r_b_vld <= 1'b1;
                r_b     <= r_rd_data;
                r_b_idx <= r_cmp_idx;
            end

            case (r_state)
                S_LOAD: begin
                    if (o_pop) begin
                        if (i_cmd.store) begin
                            r_loaded <= r_loaded + nps_pkg::CNT_W'(1);
                        end
                        if (i_cmd.last) begin
                            r_state   <= S_SCAN;
                            r_addr    <= '0;
                            r_first   <= 1'b1;
                            r_cmp_vld <= 1'b0;
                            r_e_vld   <= 1'b0;
                            r_g_vld   <= 1'b0;
                            r_b_vld   <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    r_cmp_vld <= 1'b1;
                    r_cmp_idx <= r_addr;
                    if (last_addr) begin
                        r_state <= S_TAIL;
                    end else begin
                        r_addr <= r_addr + nps_pkg::IDX_W'(1);
                    end
                end
                S_TAIL: begin
                    r_cmp_vld <= 1'b0;
                    r_state   <= S_PICK;
                end
                S_PICK: begin
                    r_sel     <= sel;
                    r_sel_idx <= sel_idx;
                    r_start   <= sel_start;
                    r_wait    <= sel_start - nps_pkg::TIME_W'(sel.arrival_time);
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    r_result.process_index     <= nps_pkg::PIDX_W'(r_sel_idx);
                    r_result.start_time        <= r_start;
                    r_result.completion_time   <= n_compl;
                    r_result.waiting_time      <= r_wait;
                    r_result.turnaround_time   <= n_turn;
                    r_result.total_waiting     <= n_sumw;
                    r_result.total_turnaround  <= n_sumt;
                    r_result.end_of_schedule   <= n_last;
                    if (n_last) begin
                        // run complete: table empties for the next batch
                        r_done   <= '0;
                        r_loaded <= '0;
                        r_ndisp  <= '0;
                        r_time   <= '0;
                        r_sumw   <= '0;
                        r_sumt   <= '0;
                        r_state  <= S_LOAD;
                    end else begin
                        r_done[r_sel_idx] <= 1'b1;
                        r_ndisp <= r_ndisp + nps_pkg::CNT_W'(1);
                        r_time  <= n_compl;
                        r_sumw  <= n_sumw;
                        r_sumt  <= n_sumt;
                        r_first <= 1'b0;
                        r_addr  <= '0;
                        r_e_vld <= 1'b0;
                        r_g_vld <= 1'b0;
                        r_b_vld <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/nonpreemptive_priority_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_core
// Non-preemptive priority scheduler: loads process records, then emits one
// dispatch result per stored record with times and running totals.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | start / busy         | i_item   (nps_pkg::t_in)
//  result   | o_valid (strobe)     | o_result (nps_pkg::t_out)
//  config   | i_cfg_we             | i_cfg_data (high_is_high)
//
//  A record transfer is taken when busy is low; a 2-entry queue lets the front
//  take records while the back is scheduling. Each dispatch scans the table once
//  through its single read port, then passes the tail, pick and emit states.
//  Reset is synchronous, active low; busy is high during reset.
//  Results cannot be stalled; each appears for exactly one cycle.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  nps_pkg::t_in  i_item,
    input  logic          i_cfg_we,
    input  logic          i_cfg_data,
    output logic          o_valid,
    output nps_pkg::t_out o_result
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    nps_pkg::t_cmd f_cmd;
    nps_pkg::t_cmd q_cmd;

    // Front: accept and classify
    nps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_busy  (busy),
        .o_push  (push),
        .o_cmd   (f_cmd)
    );

    // Decoupling queue
    nps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_cmd),
        .i_pop   (pop),
        .o_data  (q_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back: table and dispatch sequencer
    nps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (q_cmd),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

// ===== rtl/nps_checker.sv =====
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks on the scheduler core, attached by bind.
// ----------------------------------------------------------------------------
module nps_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input nps_pkg::t_out o_result
);

    // No result right after a reset cycle
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // Dispatches are separated by at least one table scan
    a_no_b2b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("back-to-back results");

    // Turnaround equals waiting plus run length
    a_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.turnaround_time ==
            nps_pkg::TIME_W'(o_result.waiting_time + o_result.completion_time
                             - o_result.start_time))
        else $error("turnaround mismatch");

    // Running totals include the current dispatch
    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.total_turnaround >=
                     nps_pkg::SUM_W'(o_result.turnaround_time)) &&
                    (o_result.total_waiting >=
                     nps_pkg::SUM_W'(o_result.waiting_time)))
        else $error("running total below current value");

endmodule

bind nonpreemptive_priority_scheduler_core nps_checker u_nps_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the non-preemptive priority scheduler. Batches of
// process records are loaded through the start/busy port. A built-in schedule
// predictor in a small scoreboard works out every dispatch, and each result
// strobe is checked field by field in order. The priority polarity is changed
// between batches, only while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 40;
    localparam int RANDOM_ITEMS = 180;

    // Schedule predictor and expected-dispatch store
    class dispatch_scoreboard;
        logic [nps_pkg::ARR_W-1:0] arr_mem [nps_pkg::MAX_PROCS];
        logic [nps_pkg::BUR_W-1:0] bur_mem [nps_pkg::MAX_PROCS];
        logic [nps_pkg::PRI_W-1:0] pri_mem [nps_pkg::MAX_PROCS];
        int                        stored;
        bit                        high_wins;
        nps_pkg::t_out             dispatch_q [$];
        int                        mismatches;

        function new();
            stored     = 0;
            high_wins  = 1'b1;
            mismatches = 0;
        endfunction

        function int pending();
            return dispatch_q.size();
        endfunction

        // Earliest arrival among unfinished records, lowest index on ties
        function int earliest_waiting(bit [nps_pkg::MAX_PROCS-1:0] finished);
            int best;
            best = -1;
            for (int i = 0; i < stored; i++) begin
                if (finished[i]) continue;
                if (best < 0 || arr_mem[i] < arr_mem[best]) best = i;
            end
            return best;
        endfunction

        // Best priority among arrived, unfinished records, lowest index on ties
        function int best_ready(bit [nps_pkg::MAX_PROCS-1:0] finished,
                                logic [nps_pkg::TIME_W-1:0]  now);
            int best;
            best = -1;
            for (int i = 0; i < stored; i++) begin
                if (finished[i] || nps_pkg::TIME_W'(arr_mem[i]) > now) continue;
                if (best < 0) begin
                    best = i;
                end else if (high_wins ? (pri_mem[i] > pri_mem[best])
                                       : (pri_mem[i] < pri_mem[best])) begin
                    best = i;
                end
            end
            return best;
        endfunction

        // Run the whole batch and queue one dispatch per stored record
        function void schedule_batch();
            bit [nps_pkg::MAX_PROCS-1:0] finished;
            logic [nps_pkg::TIME_W-1:0]  now;
            logic [nps_pkg::TIME_W-1:0]  wait_t;
            logic [nps_pkg::TIME_W-1:0]  turn_t;
            logic [nps_pkg::SUM_W-1:0]   wsum;
            logic [nps_pkg::SUM_W-1:0]   tsum;
            int                          pick;
            nps_pkg::t_out               d;
            finished = '0;
            now      = '0;
            wsum     = '0;
            tsum     = '0;
            for (int n = 0; n < stored; n++) begin
                if (n == 0) begin
                    pick = earliest_waiting(finished);
                    now  = nps_pkg::TIME_W'(arr_mem[pick]);
                end else begin
                    pick = best_ready(finished, now);
                    // idle gap: jump to the next arrival and select again
                    if (pick < 0) begin
                        now  = nps_pkg::TIME_W'(arr_mem[earliest_waiting(finished)]);
                        pick = best_ready(finished, now);
                    end
                end
                wait_t = now - nps_pkg::TIME_W'(arr_mem[pick]);
                turn_t = wait_t + nps_pkg::TIME_W'(bur_mem[pick]);
                d.process_index   = nps_pkg::PIDX_W'(pick);
                d.start_time      = now;
                now               = now + nps_pkg::TIME_W'(bur_mem[pick]);
                d.completion_time = now;
                d.waiting_time    = wait_t;
                d.turnaround_time = turn_t;
                wsum              = wsum + nps_pkg::SUM_W'(wait_t);
                tsum              = tsum + nps_pkg::SUM_W'(turn_t);
                d.total_waiting   = wsum;
                d.total_turnaround = tsum;
                d.end_of_schedule = (n == stored - 1);
                dispatch_q.push_back(d);
                finished[pick] = 1'b1;
            end
            stored = 0;
        endfunction

        // Accepted record transfer; records past a full table are dropped
        function void note_record(nps_pkg::t_in rec);
            if (stored < nps_pkg::MAX_PROCS) begin
                arr_mem[stored] = rec.arrival_time;
                bur_mem[stored] = rec.burst_time;
                pri_mem[stored] = rec.priority_level;
                stored++;
            end
            if (rec.last_process) schedule_batch();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_dispatch(nps_pkg::t_out got);
            nps_pkg::t_out want;
            if (dispatch_q.size() == 0) begin
                report_mismatch($sformatf("dispatch of process %0d with none pending",
                                          got.process_index));
                return;
            end
            want = dispatch_q.pop_front();
            check_field("process_index", 32'(got.process_index),
                        32'(want.process_index));
            check_field("start_time", 32'(got.start_time), 32'(want.start_time));
            check_field("completion_time", 32'(got.completion_time),
                        32'(want.completion_time));
            check_field("waiting_time", 32'(got.waiting_time), 32'(want.waiting_time));
            check_field("turnaround_time", 32'(got.turnaround_time),
                        32'(want.turnaround_time));
            check_field("total_waiting", 32'(got.total_waiting),
                        32'(want.total_waiting));
            check_field("total_turnaround", 32'(got.total_turnaround),
                        32'(want.total_turnaround));
            check_field("end_of_schedule", 32'(got.end_of_schedule),
                        32'(want.end_of_schedule));
        endtask
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    nps_pkg::t_in  i_item;
    logic          i_cfg_we;
    logic          i_cfg_data;
    logic          o_valid;
    nps_pkg::t_out o_result;

    dispatch_scoreboard sb;
    bit    gaps_on;
    int    cycle_count;

    nonpreemptive_priority_scheduler_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Monitor: record transfers feed the predictor, strobes are checked
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (start && busy === 1'b0) sb.note_record(i_item);
            if (o_valid === 1'b1) sb.check_dispatch(o_result);
        end
    end

    // One record transfer, with random idle cycles ahead of it
    task send_record(nps_pkg::t_in rec);
        while (gaps_on && $urandom_range(99) < 18) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_item <= rec;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Stop sending and wait until every dispatch is in and the core settles;
    // first let the monitor log the last transfer
    task drain_dispatches();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task write_polarity(bit value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        sb.high_wins = value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Record content by batch flavor: clustered, uniform, spread out, extremes
    function nps_pkg::t_in make_record(int mode);
        nps_pkg::t_in r;
        case (mode)
            0: begin
                r.arrival_time   = 16'($urandom_range(40));
                r.burst_time     = 16'($urandom_range(20));
                r.priority_level = 8'($urandom_range(3));
            end
            1: begin
                r.arrival_time   = 16'($urandom_range(65535));
                r.burst_time     = 16'($urandom_range(65535));
                r.priority_level = 8'($urandom_range(255));
            end
            2: begin
                r.arrival_time   = 16'($urandom_range(15) * 4000 + $urandom_range(99));
                r.burst_time     = 16'($urandom_range(300));
                r.priority_level = 8'($urandom_range(255));
            end
            default: begin
                r.arrival_time   = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                r.burst_time     = $urandom_range(1) ? 16'hFFFF : 16'($urandom_range(65535));
                r.priority_level = $urandom_range(1) ? 8'hFF : 8'h00;
            end
        endcase
        r.last_process = 1'b0;
        return r;
    endfunction

    nps_pkg::t_in rec;
    int  rand_items;
    int  batches;
    int  size;
    int  mode;

    initial begin
        sb          = new();
        gaps_on     = 1'b1;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n    <= 1'b1;

        // Smaller number wins for the first batches
        write_polarity(1'b0);

        // Single record, all fields zero
        send_record('{arrival_time: 16'h0, burst_time: 16'h0,
                      priority_level: 8'h0, last_process: 1'b1});
        // Single record, all fields at maximum
        send_record('{arrival_time: 16'hFFFF, burst_time: 16'hFFFF,
                      priority_level: 8'hFF, last_process: 1'b1});
        // Idle gaps: nothing has arrived when the first job finishes
        send_record('{arrival_time: 16'd100,  burst_time: 16'd5,
                      priority_level: 8'd3,   last_process: 1'b0});
        send_record('{arrival_time: 16'd2000, burst_time: 16'd7,
                      priority_level: 8'd9,   last_process: 1'b0});
        send_record('{arrival_time: 16'd100,  burst_time: 16'd0,
                      priority_level: 8'd1,   last_process: 1'b0});
        send_record('{arrival_time: 16'd50,   burst_time: 16'd10,
                      priority_level: 8'd200, last_process: 1'b1});
        drain_dispatches();
        write_polarity(1'b1);

        // Full table with priority and arrival ties; last flag on a dropped record
        for (int i = 0; i < nps_pkg::MAX_PROCS + 2; i++) begin
            rec.arrival_time   = (i < 4) ? 16'd0 : 16'(i * 2);
            rec.burst_time     = 16'(i + 1);
            rec.priority_level = (i % 3 == 0) ? 8'd7 : 8'd2;
            rec.last_process   = (i == nps_pkg::MAX_PROCS + 1);
            send_record(rec);
        end

        // Random batches; one long stretch without sender gaps
        rand_items = 0;
        batches    = 0;
        while (rand_items < RANDOM_ITEMS) begin
            size    = ($urandom_range(9) == 0) ?
                      int'($urandom_range(nps_pkg::MAX_PROCS + 1, nps_pkg::MAX_PROCS + 3)) :
                      int'($urandom_range(1, nps_pkg::MAX_PROCS));
            mode    = int'($urandom_range(3));
            gaps_on = !(rand_items >= 60 && rand_items < 110);
            for (int i = 0; i < size; i++) begin
                rec = make_record(mode);
                rec.last_process = (i == size - 1);
                send_record(rec);
                rand_items++;
            end
            batches++;
            // polarity change only with the core idle
            if (batches % 4 == 0) begin
                drain_dispatches();
                write_polarity(1'($urandom_range(1)));
            end
        end

        drain_dispatches();
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d dispatches never seen", sb.pending()));
        end
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
